// ===== rtl/core/prd_pkg.sv =====
// Package for the pulse rate detector core.
// Holds field widths, register indexes, word layouts and the sequencer state type.
// No dependencies.
package prd_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int TIME_BITS    = 32;
    localparam int HOLDOFF_BITS = 8;
    localparam int RATE_BITS    = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;

    localparam int IN_W        = SAMPLE_BITS + TIME_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = RATE_BITS + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [RATE_BITS-1:0] RATE_NUMER = RATE_BITS'(60000);
    localparam logic [RATE_BITS-1:0] RATE_SAT   = RATE_BITS'(60000);

    localparam logic [SAMPLE_BITS-1:0]  UPPER_RST   = SAMPLE_BITS'(560);
    localparam logic [SAMPLE_BITS-1:0]  LOWER_RST   = SAMPLE_BITS'(530);
    localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RST = HOLDOFF_BITS'(20);
    localparam logic [RATE_BITS-1:0]    MIN_RST     = RATE_BITS'(60);
    localparam logic [RATE_BITS-1:0]    MAX_RST     = RATE_BITS'(175);

    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_THR = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_THR = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE  = CFG_INDEX_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_OUT
    } prd_state_t;

endpackage

// ===== rtl/core/pulse_rate_detector_core.sv =====
// Top level of the pulse rate detector: beat detection with hysteresis and rate output.
// Depends on prd_pkg and prd_div.
//
// Each input word carries one ADC sample and its millisecond timestamp and yields exactly
// one output word with the held rate in beats per minute, a flag for a freshly computed
// rate and an in-window indicator. A word that needs no division passes from acceptance
// through the evaluation state to the output state, which loads the output register. A word
// that completes a beat with an elapsed time from 1 to 60000 ms runs the rate division
// through a restoring divider that produces one quotient bit per cycle; such a word is
// evaluated and loads the divider, then takes sixteen divider steps, has its quotient taken
// and then loads the output register. The block takes one word at a time and is ready
// again in the cycle after the output register loads; a finished output word may wait in
// its register while the next input word is taken. Configuration is written through the
// plain write port; the user must write it only while idle, the block does not enforce it.
module pulse_rate_detector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [prd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: sample, time_ms, zero fill.
    input  logic [prd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0 up: rate_bpm, new_rate, rate_in_window, zero fill.
    output logic [prd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int SB = prd_pkg::SAMPLE_BITS;
    localparam int TB = prd_pkg::TIME_BITS;
    localparam int RB = prd_pkg::RATE_BITS;
    localparam int HB = prd_pkg::HOLDOFF_BITS;

    prd_pkg::prd_state_t state_reg, state_next;

    logic [SB-1:0] upper_reg, lower_reg;
    logic [HB-1:0] holdoff_reg;
    logic [RB-1:0] min_reg, max_reg;

    logic          timing_reg, timing_next;
    logic          complete_reg, complete_next;
    logic [TB-1:0] start_reg, start_next;
    logic [RB-1:0] held_reg, held_next;
    logic          fresh_reg, fresh_next;

    logic [SB-1:0] sample_reg;
    logic [TB-1:0] time_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [RB-1:0]         m_rate_reg;
    logic                  m_fresh_reg, m_window_reg;
    logic                  out_load;

    logic [TB-1:0] ahead, elapsed;
    logic          holdoff_skip, above_upper, below_lower;
    logic          div_start, div_done;
    logic [RB-1:0] div_quo;

    assign ahead        = start_reg - time_reg;
    assign elapsed      = time_reg - start_reg;
    assign holdoff_skip = timing_reg && (ahead != '0) && (ahead <= TB'(holdoff_reg));
    assign above_upper  = sample_reg > upper_reg;
    assign below_lower  = sample_reg < lower_reg;
    assign out_load     = (state_reg == prd_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    prd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (elapsed[RB-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        timing_next   = timing_reg;
        complete_next = complete_reg;
        start_next    = start_reg;
        held_next     = held_reg;
        fresh_next    = fresh_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            prd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = prd_pkg::ST_EVAL;
                end
            end
            prd_pkg::ST_EVAL: begin
                fresh_next = 1'b0;
                state_next = prd_pkg::ST_OUT;
                if (!holdoff_skip) begin
                    if (above_upper && complete_reg) begin
                        fresh_next    = 1'b1;
                        timing_next   = 1'b1;
                        start_next    = time_reg + TB'(holdoff_reg);
                        complete_next = below_lower;
                        if (elapsed == '0) begin
                            held_next = prd_pkg::RATE_SAT;
                        end else if (elapsed > TB'(prd_pkg::RATE_NUMER)) begin
                            held_next = '0;
                        end else begin
                            div_start  = 1'b1;
                            state_next = prd_pkg::ST_DIV;
                        end
                    end else begin
                        if (above_upper && !timing_reg) begin
                            timing_next = 1'b1;
                            start_next  = time_reg + TB'(holdoff_reg);
                        end
                        if (below_lower && (timing_reg || above_upper)) begin
                            complete_next = 1'b1;
                        end
                    end
                end
            end
            prd_pkg::ST_DIV: begin
                if (div_done) begin
                    held_next  = div_quo;
                    state_next = prd_pkg::ST_OUT;
                end
            end
            prd_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = prd_pkg::ST_IDLE;
                end
            end
            default: state_next = prd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= prd_pkg::ST_IDLE;
            upper_reg    <= prd_pkg::UPPER_RST;
            lower_reg    <= prd_pkg::LOWER_RST;
            holdoff_reg  <= prd_pkg::HOLDOFF_RST;
            min_reg      <= prd_pkg::MIN_RST;
            max_reg      <= prd_pkg::MAX_RST;
            timing_reg   <= 1'b0;
            complete_reg <= 1'b0;
            start_reg    <= '0;
            held_reg     <= '0;
            fresh_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            timing_reg   <= timing_next;
            complete_reg <= complete_next;
            start_reg    <= start_next;
            held_reg     <= held_next;
            fresh_reg    <= fresh_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    prd_pkg::REG_UPPER_THR: upper_reg   <= cfg_wdata[SB-1:0];
                    prd_pkg::REG_LOWER_THR: lower_reg   <= cfg_wdata[SB-1:0];
                    prd_pkg::REG_HOLDOFF:   holdoff_reg <= cfg_wdata[HB-1:0];
                    prd_pkg::REG_MIN_RATE:  min_reg     <= cfg_wdata[RB-1:0];
                    prd_pkg::REG_MAX_RATE:  max_reg     <= cfg_wdata[RB-1:0];
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[SB-1:0];
            time_reg   <= s_tdata[SB+TB-1:SB];
        end
        if (out_load) begin
            m_rate_reg   <= held_reg;
            m_fresh_reg  <= fresh_reg;
            m_window_reg <= (held_reg >= min_reg) && (held_reg <= max_reg);
        end
    end

    assign s_tready = (state_reg == prd_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(prd_pkg::OUT_TDATA_W - prd_pkg::OUT_W)'(0),
                       m_window_reg, m_fresh_reg, m_rate_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == prd_pkg::ST_EVAL))
        else $error("Accepted word did not start evaluation.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == prd_pkg::ST_DIV))
        else $error("Divider finished outside the division state.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == prd_pkg::ST_OUT) && fresh_reg) |-> timing_reg)
        else $error("Fresh rate without timing restarted.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= prd_pkg::RATE_SAT)
        else $error("Held rate exceeds saturation value.");

endmodule

// ===== rtl/core/prd_div.sv =====
// Restoring divider that computes the rate constant divided by a 16-bit divisor.
// One quotient bit per cycle; uses prd_pkg.
module prd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [prd_pkg::RATE_BITS-1:0]  divisor,
    output logic                           done,
    output logic [prd_pkg::RATE_BITS-1:0]  quotient
);

    localparam int CNT_W = $clog2(prd_pkg::RATE_BITS);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [prd_pkg::RATE_BITS-1:0] rem_reg, rem_next;
    logic [prd_pkg::RATE_BITS-1:0] quo_reg, quo_next;
    logic [prd_pkg::RATE_BITS-1:0] dvs_reg, dvs_next;
    logic [prd_pkg::RATE_BITS:0]   trial;
    logic [prd_pkg::RATE_BITS:0]   diff;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[prd_pkg::RATE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = prd_pkg::RATE_NUMER;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[prd_pkg::RATE_BITS-1:0] : trial[prd_pkg::RATE_BITS-1:0];
            quo_next = {quo_reg[prd_pkg::RATE_BITS-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(prd_pkg::RATE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
